### rtl/core/mm_pkg.sv
// mm_pkg: shared types and constants for the matrix multiply block
// holds payload structs, field widths, item kinds and register indexes
// no dependencies
`timescale 1ns / 1ps

package mm_pkg;

    // matrix size limit and derived widths
    localparam int MAX_DIM   = 8;
    localparam int IDX_W     = 3;
    localparam int ADDR_W    = $clog2(MAX_DIM * MAX_DIM);
    localparam int DIM_W     = 4;
    localparam int ELEM_W    = 32;
    localparam int FRAC_W    = 16;
    localparam int PROD_W    = 2 * ELEM_W;
    localparam int ACC_W     = PROD_W + $clog2(MAX_DIM);

    // item kinds
    localparam logic [1:0] KIND_LOAD_A = 2'd0;
    localparam logic [1:0] KIND_LOAD_B = 2'd1;
    localparam logic [1:0] KIND_START  = 2'd2;

    // configuration register indexes
    localparam logic [1:0] REG_ROWS_A    = 2'd0;
    localparam logic [1:0] REG_INNER_DIM = 2'd1;
    localparam logic [1:0] REG_COLS_B    = 2'd2;

    // input transaction
    typedef struct packed {
        logic [1:0]               kind;
        logic [IDX_W-1:0]         row;
        logic [IDX_W-1:0]         col;
        logic signed [ELEM_W-1:0] value;
    } item_t;

    // output transaction
    typedef struct packed {
        logic [IDX_W-1:0]         out_row;
        logic [IDX_W-1:0]         out_col;
        logic signed [ELEM_W-1:0] product;
        logic                     overflow;
        logic                     last;
    } result_t;

endpackage

### rtl/core/matrix_multiply.sv
// matrix_multiply: dense C = A * B on signed Q16.16 elements
// depends on mm_pkg for payload types, widths and codes
`timescale 1ns / 1ps
//
// Usage
//   item channel (item_valid / item_stall / item): kind 0 and 1 write one
//   element of A or B at (row, col); kind 2 starts a run; kind 3 is dropped.
//   Loads stream at one transaction per cycle while no run is in progress.
//   result channel (result_valid / result_stall / result): one transaction per
//   element of C in row-major order, last set on the final one.
//   cfg channel (cfg_valid / cfg_ready / cfg_index / cfg_data): rows_a,
//   inner_dim, cols_b; always ready. Dimensions are clamped to 1..8 at start.
// Run
//   a run issues one A/B read pair per cycle from the two element memories,
//   except while a waiting result is stalled, and holds item_stall high until
//   its final read pair; result_valid rises once per element of C, after its
//   last inner step has passed the accumulate register.
//   Pipeline: memory read, multiply, accumulate, saturate into output register.
// Reset clears control and sets all dimensions to 8; the element memories are
// not cleared and must be written before they are used.
// While result_stall holds a waiting result, the whole pipeline freezes.

module matrix_multiply (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_stall,
    input  mm_pkg::item_t    item,
    output logic             result_valid,
    input  logic             result_stall,
    output mm_pkg::result_t  result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [1:0]       cfg_index,
    input  logic [mm_pkg::DIM_W-1:0] cfg_data
);

    localparam int IW = mm_pkg::IDX_W;

    // clamp a dimension register to 1..MAX_DIM, returned as count minus one
    function automatic logic [IW-1:0] clamp_last(input logic [mm_pkg::DIM_W-1:0] d);
        logic [IW-1:0] r;
        if (d == '0)
            r = '0;
        else if (d > mm_pkg::DIM_W'(mm_pkg::MAX_DIM))
            r = IW'(mm_pkg::MAX_DIM - 1);
        else
            r = IW'(d - 1'b1);
        return r;
    endfunction

    // configuration registers
    logic [mm_pkg::DIM_W-1:0] rows_a_reg, inner_dim_reg, cols_b_reg;

    // sequencer
    logic          run_reg, run_next;
    logic [IW-1:0] i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [IW-1:0] ml_reg, ml_next, nl_reg, nl_next, ql_reg, ql_next;

    // pipeline tags
    logic          s1_valid_reg, s1_first_reg, s1_lastk_reg, s1_lastel_reg;
    logic [IW-1:0] s1_i_reg, s1_j_reg;
    logic          s2_valid_reg, s2_first_reg, s2_lastk_reg, s2_lastel_reg;
    logic [IW-1:0] s2_i_reg, s2_j_reg;
    logic          acc_done_reg, acc_lastel_reg;
    logic [IW-1:0] acc_i_reg, acc_j_reg;

    // datapath
    logic signed [mm_pkg::ELEM_W-1:0] a_rd_reg, b_rd_reg;
    logic signed [mm_pkg::PROD_W-1:0] prod_reg;
    logic signed [mm_pkg::ACC_W-1:0]  acc_reg;
    logic signed [mm_pkg::ACC_W-1:0]  prod_ext, shifted;
    logic                             sat_pos, sat_neg;

    logic            result_valid_reg;
    mm_pkg::result_t result_reg;

    // element memories
    logic [mm_pkg::ELEM_W-1:0] mem_a [mm_pkg::MAX_DIM*mm_pkg::MAX_DIM];
    logic [mm_pkg::ELEM_W-1:0] mem_b [mm_pkg::MAX_DIM*mm_pkg::MAX_DIM];

    logic                    item_fire, load_ok, hold, issue;
    logic [mm_pkg::ADDR_W-1:0] wr_addr, rd_addr_a, rd_addr_b;

    // handshake
    assign item_stall   = run_reg;
    assign item_fire    = item_valid && !run_reg;
    assign cfg_ready    = 1'b1;
    assign hold         = result_valid_reg && result_stall;
    assign issue        = run_reg && !hold;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // addresses
    assign load_ok   = (32'(item.row) < mm_pkg::MAX_DIM) && (32'(item.col) < mm_pkg::MAX_DIM);
    assign wr_addr   = mm_pkg::ADDR_W'(32'(item.row) * mm_pkg::MAX_DIM + 32'(item.col));
    assign rd_addr_a = mm_pkg::ADDR_W'(32'(i_reg) * mm_pkg::MAX_DIM + 32'(k_reg));
    assign rd_addr_b = mm_pkg::ADDR_W'(32'(k_reg) * mm_pkg::MAX_DIM + 32'(j_reg));

    // memory A: load write, registered read on issue
    always_ff @(posedge clk)
    begin
        if (item_fire && item.kind == mm_pkg::KIND_LOAD_A && load_ok)
            mem_a[wr_addr] <= item.value;
        if (issue)
            a_rd_reg <= mem_a[rd_addr_a];
    end

    // memory B: load write, registered read on issue
    always_ff @(posedge clk)
    begin
        if (item_fire && item.kind == mm_pkg::KIND_LOAD_B && load_ok)
            mem_b[wr_addr] <= item.value;
        if (issue)
            b_rd_reg <= mem_b[rd_addr_b];
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_a_reg    <= mm_pkg::DIM_W'(8);
            inner_dim_reg <= mm_pkg::DIM_W'(8);
            cols_b_reg    <= mm_pkg::DIM_W'(8);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                mm_pkg::REG_ROWS_A:    rows_a_reg    <= cfg_data;
                mm_pkg::REG_INNER_DIM: inner_dim_reg <= cfg_data;
                mm_pkg::REG_COLS_B:    cols_b_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer next state: k innermost, then j, then i
    always_comb
    begin
        run_next = run_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        k_next   = k_reg;
        ml_next  = ml_reg;
        nl_next  = nl_reg;
        ql_next  = ql_reg;
        if (item_fire && item.kind == mm_pkg::KIND_START)
        begin
            run_next = 1'b1;
            i_next   = '0;
            j_next   = '0;
            k_next   = '0;
            ml_next  = clamp_last(rows_a_reg);
            nl_next  = clamp_last(inner_dim_reg);
            ql_next  = clamp_last(cols_b_reg);
        end
        else if (issue)
        begin
            if (k_reg == nl_reg)
            begin
                k_next = '0;
                if (j_reg == ql_reg)
                begin
                    j_next = '0;
                    if (i_reg == ml_reg)
                        run_next = 1'b0;
                    else
                        i_next = i_reg + 1'b1;
                end
                else
                    j_next = j_reg + 1'b1;
            end
            else
                k_next = k_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg <= 1'b0;
            i_reg   <= '0;
            j_reg   <= '0;
            k_reg   <= '0;
            ml_reg  <= '0;
            nl_reg  <= '0;
            ql_reg  <= '0;
        end
        else
        begin
            run_reg <= run_next;
            i_reg   <= i_next;
            j_reg   <= j_next;
            k_reg   <= k_next;
            ml_reg  <= ml_next;
            nl_reg  <= nl_next;
            ql_reg  <= ql_next;
        end
    end

    // pipeline control tags, frozen while the output is stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            acc_done_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else if (!hold)
        begin
            s1_valid_reg     <= issue;
            s2_valid_reg     <= s1_valid_reg;
            acc_done_reg     <= s2_valid_reg && s2_lastk_reg;
            result_valid_reg <= acc_done_reg;
        end
    end

    // saturation of the accumulated sum after the floor shift
    assign prod_ext = mm_pkg::ACC_W'(prod_reg);
    assign shifted  = acc_reg >>> mm_pkg::FRAC_W;
    assign sat_pos  = !shifted[mm_pkg::ACC_W-1] && (|shifted[mm_pkg::ACC_W-2:mm_pkg::ELEM_W-1]);
    assign sat_neg  = shifted[mm_pkg::ACC_W-1] && !(&shifted[mm_pkg::ACC_W-2:mm_pkg::ELEM_W-1]);

    // datapath: multiply, accumulate, output register
    always_ff @(posedge clk)
    begin
        if (!hold)
        begin
            s1_first_reg  <= (k_reg == '0);
            s1_lastk_reg  <= (k_reg == nl_reg);
            s1_lastel_reg <= (i_reg == ml_reg) && (j_reg == ql_reg);
            s1_i_reg      <= i_reg;
            s1_j_reg      <= j_reg;

            prod_reg      <= a_rd_reg * b_rd_reg;
            s2_first_reg  <= s1_first_reg;
            s2_lastk_reg  <= s1_lastk_reg;
            s2_lastel_reg <= s1_lastel_reg;
            s2_i_reg      <= s1_i_reg;
            s2_j_reg      <= s1_j_reg;

            if (s2_valid_reg)
            begin
                acc_reg        <= s2_first_reg ? prod_ext : acc_reg + prod_ext;
                acc_lastel_reg <= s2_lastel_reg;
                acc_i_reg      <= s2_i_reg;
                acc_j_reg      <= s2_j_reg;
            end

            result_reg.out_row  <= acc_i_reg;
            result_reg.out_col  <= acc_j_reg;
            result_reg.last     <= acc_lastel_reg;
            result_reg.overflow <= sat_pos || sat_neg;
            if (sat_pos)
                result_reg.product <= {1'b0, {(mm_pkg::ELEM_W-1){1'b1}}};
            else if (sat_neg)
                result_reg.product <= {1'b1, {(mm_pkg::ELEM_W-1){1'b0}}};
            else
                result_reg.product <= shifted[mm_pkg::ELEM_W-1:0];
        end
    end

    // a stalled result freezes the sequencer
    assert property (@(posedge clk) disable iff (!rst_n)
        hold && run_reg |=> $stable(i_reg) && $stable(j_reg) && $stable(k_reg) && run_reg)
        else $error("sequencer moved while output stalled");

    // the final read pair ends the run
    assert property (@(posedge clk) disable iff (!rst_n)
        issue && i_reg == ml_reg && j_reg == ql_reg && k_reg == nl_reg |=> !run_reg)
        else $error("run did not end after final read");

    // the last inner step of a valid read always yields a finished element
    assert property (@(posedge clk) disable iff (!rst_n)
        !hold && s2_valid_reg && s2_lastk_reg |=> acc_done_reg)
        else $error("accumulated element lost");

endmodule
